>>> hw/rtl/ps2sa_pkg.sv
// Package for the PS/2 set-1 scan code decoder and key queue.
// Holds scan code constants, the decode result type and the lookup tables.
// No dependencies.
package ps2sa_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int KEY_W           = 8;
	localparam int LEVEL_W         = 5;

	localparam logic [7:0] SC_PREFIX   = 8'hE0;
	localparam logic [7:0] SC_LSHIFT   = 8'h2A;
	localparam logic [7:0] SC_RSHIFT   = 8'h36;
	localparam logic [7:0] SC_LSHIFT_B = 8'hAA;
	localparam logic [7:0] SC_RSHIFT_B = 8'hB6;
	localparam logic [7:0] SC_EXT_LEFT  = 8'h4B;
	localparam logic [7:0] SC_EXT_RIGHT = 8'h4D;
	localparam logic [7:0] SC_EXT_UP    = 8'h48;
	localparam logic [7:0] SC_EXT_DOWN  = 8'h50;
	localparam logic [7:0] SC_EXT_DEL   = 8'h53;

	localparam logic [7:0] KEY_NONE   = 8'd0;
	localparam logic [7:0] KEY_LEFT   = 8'd128;
	localparam logic [7:0] KEY_RIGHT  = 8'd129;
	localparam logic [7:0] KEY_UP     = 8'd130;
	localparam logic [7:0] KEY_DOWN   = 8'd131;
	localparam logic [7:0] KEY_DELETE = 8'd132;

	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_UPPER_A = 8'h41;

	typedef struct packed {
		logic             key_vld;
		logic [KEY_W-1:0] key;
	} dec_res_t;

	function automatic logic [7:0] ext_key(input logic [7:0] code);
		case (code)
			SC_EXT_LEFT:  return KEY_LEFT;
			SC_EXT_RIGHT: return KEY_RIGHT;
			SC_EXT_UP:    return KEY_UP;
			SC_EXT_DOWN:  return KEY_DOWN;
			SC_EXT_DEL:   return KEY_DELETE;
			default:      return KEY_NONE;
		endcase
	endfunction

	function automatic logic [7:0] plain_tab(input logic [6:0] code);
		case (code)
			7'h02: return 8'h31;
			7'h03: return 8'h32;
			7'h04: return 8'h33;
			7'h05: return 8'h34;
			7'h06: return 8'h35;
			7'h07: return 8'h36;
			7'h08: return 8'h37;
			7'h09: return 8'h38;
			7'h0A: return 8'h39;
			7'h0B: return 8'h30;
			7'h0C: return 8'h2D;
			7'h0D: return 8'h3D;
			7'h0E: return 8'h08;
			7'h0F: return 8'h09;
			7'h10: return 8'h71;
			7'h11: return 8'h77;
			7'h12: return 8'h65;
			7'h13: return 8'h72;
			7'h14: return 8'h74;
			7'h15: return 8'h79;
			7'h16: return 8'h75;
			7'h17: return 8'h69;
			7'h18: return 8'h6F;
			7'h19: return 8'h70;
			7'h1A: return 8'h5B;
			7'h1B: return 8'h5D;
			7'h1C: return 8'h0A;
			7'h1E: return 8'h61;
			7'h1F: return 8'h73;
			7'h20: return 8'h64;
			7'h21: return 8'h66;
			7'h22: return 8'h67;
			7'h23: return 8'h68;
			7'h24: return 8'h6A;
			7'h25: return 8'h6B;
			7'h26: return 8'h6C;
			7'h27: return 8'h3B;
			7'h28: return 8'h27;
			7'h29: return 8'h60;
			7'h2B: return 8'h5C;
			7'h2C: return 8'h7A;
			7'h2D: return 8'h78;
			7'h2E: return 8'h63;
			7'h2F: return 8'h76;
			7'h30: return 8'h62;
			7'h31: return 8'h6E;
			7'h32: return 8'h6D;
			7'h33: return 8'h2C;
			7'h34: return 8'h2E;
			7'h35: return 8'h2F;
			7'h39: return 8'h20;
			default: return KEY_NONE;
		endcase
	endfunction

	function automatic logic [7:0] shift_tab(input logic [6:0] code);
		case (code)
			7'h02: return 8'h21;
			7'h03: return 8'h40;
			7'h04: return 8'h23;
			7'h05: return 8'h24;
			7'h06: return 8'h25;
			7'h07: return 8'h5E;
			7'h08: return 8'h26;
			7'h09: return 8'h2A;
			7'h0A: return 8'h28;
			7'h0B: return 8'h29;
			7'h0C: return 8'h5F;
			7'h0D: return 8'h2B;
			7'h1A: return 8'h7B;
			7'h1B: return 8'h7D;
			7'h27: return 8'h3A;
			7'h28: return 8'h22;
			7'h29: return 8'h7E;
			7'h2B: return 8'h7C;
			7'h33: return 8'h3C;
			7'h34: return 8'h3E;
			7'h35: return 8'h3F;
			default: return KEY_NONE;
		endcase
	endfunction

	function automatic logic [7:0] plain_key(input logic [6:0] code, input logic shift);
		logic [7:0] up;
		logic [7:0] c;
		up = shift_tab(code);
		c  = plain_tab(code);
		if (shift && up != KEY_NONE) begin
			return up;
		end
		if (shift && c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
			c = c - (CH_LOWER_A - CH_UPPER_A);
		end
		return c;
	endfunction

endpackage

>>> hw/rtl/ps2sa_if.sv
// Handshake interfaces for the scan code decoder: request and response words.
// Widths are written out in the interfaces; no dependency on ps2sa_pkg.
interface ps2sa_req_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] scan_byte;

	modport source(output valid, action, scan_byte, input ready);
	modport sink(input valid, action, scan_byte, output ready);
endinterface

interface ps2sa_rsp_if;
	logic       valid;
	logic       ready;
	logic       key_queued;
	logic       key_dropped;
	logic       pop_valid;
	logic [7:0] popped_key;
	logic [4:0] queue_level;

	modport source(output valid, key_queued, key_dropped, pop_valid, popped_key,
		queue_level, input ready);
	modport sink(input valid, key_queued, key_dropped, pop_valid, popped_key,
		queue_level, output ready);
endinterface

>>> hw/rtl/ps2_scancode_to_ascii_fifo_core.sv
// PS/2 set-1 scan code to ASCII decoder with a key queue held in RAM.
// A request word passes the stage-one register (RAM registered read) and then the output register to its response word.
// Throughput: one word per cycle while the response side is ready; the RAM takes one push or one pop per cycle.
// Reset clears shift/prefix flags, queue pointers and fill count; queue RAM is not cleared.
// Depends on ps2sa_pkg, ps2sa_if, ps2sa_ram, ps2sa_decode.
module ps2_scancode_to_ascii_fifo_core #(
	parameter int QUEUE_DEPTH = ps2sa_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ps2sa_req_if.sink   req,
	ps2sa_rsp_if.source rsp
);
	import ps2sa_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int XW = (CW > LEVEL_W) ? CW : LEVEL_W;

	logic          accept;
	dec_res_t      dec;
	logic          full;
	logic          do_push;
	logic          do_drop;
	logic          do_pop;
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_d;
	logic [XW-1:0] cnt_ext;
	logic [KEY_W-1:0] rdata;

	logic               v_s1;
	logic               queued_s1;
	logic               dropped_s1;
	logic               pop_s1;
	logic [LEVEL_W-1:0] level_s1;
	logic               s1_go;

	logic               out_v_q;
	logic               queued_q;
	logic               dropped_q;
	logic               pop_q;
	logic [KEY_W-1:0]   key_q;
	logic [LEVEL_W-1:0] level_q;

	assign s1_go     = v_s1 && (!out_v_q || rsp.ready);
	assign req.ready = !v_s1 || s1_go;
	assign accept    = req.valid && req.ready;

	ps2sa_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (accept && !req.action),
		.scan_byte (req.scan_byte),
		.res       (dec)
	);

	assign full    = (cnt_q == CW'(QUEUE_DEPTH));
	assign do_push = accept && !req.action && dec.key_vld && !full;
	assign do_drop = accept && !req.action && dec.key_vld && full;
	assign do_pop  = accept && req.action && (cnt_q != '0);

	always_comb begin
		cnt_d = cnt_q;
		if (do_push) begin
			cnt_d = cnt_q + CW'(1);
		end else if (do_pop) begin
			cnt_d = cnt_q - CW'(1);
		end
	end

	assign cnt_ext = XW'(cnt_d);

	ps2sa_ram #(
		.WIDTH (KEY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (do_push),
		.waddr (wp_q),
		.wdata (dec.key),
		.re    (do_pop),
		.raddr (rp_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
			if (do_push) begin
				wp_q <= (wp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + PW'(1);
			end
			if (do_pop) begin
				rp_q <= (rp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + PW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (s1_go) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			queued_s1  <= do_push;
			dropped_s1 <= do_drop;
			pop_s1     <= do_pop;
			level_s1   <= cnt_ext[LEVEL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s1_go) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			queued_q  <= queued_s1;
			dropped_q <= dropped_s1;
			pop_q     <= pop_s1;
			key_q     <= pop_s1 ? rdata : KEY_NONE;
			level_q   <= level_s1;
		end
	end

	assign rsp.valid       = out_v_q;
	assign rsp.key_queued  = queued_q;
	assign rsp.key_dropped = dropped_q;
	assign rsp.pop_valid   = pop_q;
	assign rsp.popped_key  = key_q;
	assign rsp.queue_level = level_q;
endmodule

>>> hw/rtl/ps2sa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read data holds while no read is issued. No dependencies.
module ps2sa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

>>> hw/rtl/ps2sa_decode.sv
// Scan code decoder: shift and extended-prefix flags plus table lookup.
// Depends on ps2sa_pkg.
module ps2sa_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [7:0]          scan_byte,
	output ps2sa_pkg::dec_res_t res
);
	import ps2sa_pkg::*;

	logic       shift_q;
	logic       prefix_q;
	logic       shift_d;
	logic       prefix_d;
	logic [7:0] key;

	always_comb begin
		shift_d  = shift_q;
		prefix_d = prefix_q;
		key      = KEY_NONE;
		if (scan_byte == SC_PREFIX) begin
			prefix_d = 1'b1;
		end else if (prefix_q) begin
			prefix_d = 1'b0;
			if (!scan_byte[7]) begin
				key = ext_key(scan_byte);
			end
		end else if (scan_byte inside {SC_LSHIFT, SC_RSHIFT}) begin
			shift_d = 1'b1;
		end else if (scan_byte inside {SC_LSHIFT_B, SC_RSHIFT_B}) begin
			shift_d = 1'b0;
		end else if (!scan_byte[7]) begin
			key = plain_key(scan_byte[6:0], shift_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q  <= 1'b0;
			prefix_q <= 1'b0;
		end else if (en) begin
			shift_q  <= shift_d;
			prefix_q <= prefix_d;
		end
	end

	assign res.key_vld = (key != KEY_NONE);
	assign res.key     = key;
endmodule
